// ===== hw/rtl/integer_radix_formatter_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the integer radix formatter
// Shared macros that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef INTEGER_RADIX_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_RADIX_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define IRF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define IRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/irf_pkg.sv =====
// ----------------------------------------------------------------------------
// irf_pkg
// Types, constants and the digit-to-character function of the radix formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package irf_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_FIELD_DEF  = 63;

    localparam int DIGIT_W   = 6;   // one digit value, also the radix width
    localparam int FIELD_W   = 6;   // field width and minimum digit count
    localparam int LEN_W     = 8;   // character counts of one item
    localparam int DIV_R     = 4;   // quotient bits per divider cycle
    localparam int RADIX_MIN = 2;
    localparam int RADIX_MAX = 36;
    localparam int X_DIGIT   = 33;  // digit value of the x in the prefix

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_LOWER = 8'h61;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_SETUP,
        S_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_SIGN,
        PH_PFX0,
        PH_PFXX,
        PH_ZPAD,
        PH_PREC,
        PH_DIGS,
        PH_TRAIL,
        PH_ERR
    } phase_t;

    typedef struct packed {
        logic             bad;
        logic             lead_sp;
        logic             trail_sp;
        logic             zpad;
        logic             has_sign;
        logic [7:0]       sign_char;
        logic [1:0]       prefix_len;
        logic             lower;
        logic [LEN_W-1:0] pad;
        logic [LEN_W-1:0] extra;
        logic [LEN_W-1:0] ndig;
        logic [LEN_W-1:0] out_len;
    } fmt_t;

    // Digit value to ASCII, upper or lower case letters above nine.
    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d,
                                              input logic lower);
        logic [7:0] base;
        if (d < DIGIT_W'(10)) begin
            digit_char = CH_ZERO + 8'(d);
        end else begin
            base = lower ? CH_LOWER : CH_UPPER;
            digit_char = base + 8'(d) - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/integer_radix_formatter_core.sv =====
// Sequence: each digit takes a pass through the shared divider (S_DIV_START, then S_DIV_WAIT),
// then S_SETUP lays out the field, then S_EMIT sends the characters phase by phase.
// Items are taken one at a time; the digit loop and the character count set the time per item,
// and m_ready low stalls the character output.
// The result register frees the input side while the final character waits. aresetn is
// synchronous and active low; it clears the control state and result valid, not the payload.
`default_nettype none
`include "integer_radix_formatter_core_defines.svh"

// ----------------------------------------------------------------------------
// integer_radix_formatter_core
// Formats one integer per item as printf-style ASCII in radix 2 to 36.
// ----------------------------------------------------------------------------
module integer_radix_formatter_core #(
    parameter int VALUE_BITS = irf_pkg::VALUE_BITS_DEF,
    parameter int MAX_FIELD  = irf_pkg::MAX_FIELD_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [VALUE_BITS-1:0]       s_value,
    input  wire logic [irf_pkg::DIGIT_W-1:0] s_radix,
    input  wire logic [irf_pkg::FIELD_W-1:0] s_field_width,
    input  wire logic [irf_pkg::FIELD_W-1:0] s_min_digits,
    input  wire logic                        s_is_signed,
    input  wire logic                        s_left_justify,
    input  wire logic                        s_plus_sign,
    input  wire logic                        s_space_sign,
    input  wire logic                        s_alt_prefix,
    input  wire logic                        s_zero_pad,
    input  wire logic                        s_lower_case,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [7:0]                       m_char_out,
    output logic                             m_last,
    output logic                             m_bad_radix
);
    import irf_pkg::*;

    // Sequencer state. The item fields are captured when the item is taken.
    ctrl_state_t        state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg;
    logic [DIGIT_W-1:0] radix_reg;
    logic [FIELD_W-1:0] fw_reg;
    logic [FIELD_W-1:0] mind_reg;
    logic               bad_reg;
    logic               left_reg;
    logic               zpad_reg;
    logic               lower_reg;
    logic               has_sign_reg;
    logic [7:0]         sign_char_reg;
    logic [1:0]         prefix_len_reg;
    logic [LEN_W-1:0]   ndig_reg;

    logic               accept;
    logic               div_start;
    logic               div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [DIGIT_W-1:0] div_rem;
    logic               push;
    logic               emit_start;
    logic               emit_done;
    logic               emit_active;
    logic               pop;
    logic [DIGIT_W-1:0] top_digit;

    // Sign and prefix of the incoming item.
    logic               in_bad;
    logic               in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic               in_has_sign;
    logic [7:0]         in_sign_char;
    logic [1:0]         in_prefix_len;

    // Field layout, worked out once the digit count is known.
    logic [LEN_W-1:0]   prec;
    logic [LEN_W-1:0]   need;
    logic [LEN_W-1:0]   total;
    fmt_t               fmt;

    assign accept = s_valid && s_ready;

    always_comb begin
        in_bad = (s_radix < DIGIT_W'(RADIX_MIN)) || (s_radix > DIGIT_W'(RADIX_MAX));
        in_neg = s_is_signed && s_value[VALUE_BITS-1];
        in_mag = in_neg ? (VALUE_BITS'(0) - s_value) : s_value;
        // A minus sign wins over a plus, and a plus wins over a space.
        if (in_neg) begin
            in_has_sign  = 1'b1;
            in_sign_char = CH_MINUS;
        end else if (s_plus_sign) begin
            in_has_sign  = 1'b1;
            in_sign_char = CH_PLUS;
        end else if (s_space_sign) begin
            in_has_sign  = 1'b1;
            in_sign_char = CH_SPACE;
        end else begin
            in_has_sign  = 1'b0;
            in_sign_char = CH_NUL;
        end
        // The alternate prefix exists only for hex and octal.
        if (s_alt_prefix && s_radix == DIGIT_W'(16)) begin
            in_prefix_len = 2'd2;
        end else if (s_alt_prefix && s_radix == DIGIT_W'(8)) begin
            in_prefix_len = 2'd1;
        end else begin
            in_prefix_len = 2'd0;
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = in_bad ? S_SETUP : S_DIV_START;
                end
            end
            S_DIV_START: begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (div_quot == '0) ? S_SETUP : S_DIV_START;
                end
            end
            S_SETUP: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (emit_done) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        s_ready    = (state_reg == S_IDLE);
        div_start  = (state_reg == S_DIV_START);
        push       = (state_reg == S_DIV_WAIT) && div_done;
        emit_start = (state_reg == S_SETUP);
    end

    // The digit count is at least one, since a zero value still yields one digit.
    // Padding fills the field after the sign, the prefix and the zero-padded digits.
    always_comb begin
        prec  = (ndig_reg > LEN_W'(mind_reg)) ? ndig_reg : LEN_W'(mind_reg);
        need  = LEN_W'(has_sign_reg) + LEN_W'(prefix_len_reg) + prec;
        total = (LEN_W'(fw_reg) > need) ? LEN_W'(fw_reg) : need;

        fmt.bad        = bad_reg;
        fmt.lead_sp    = !left_reg && !zpad_reg;
        fmt.trail_sp   = left_reg;
        fmt.zpad       = zpad_reg && !left_reg;
        fmt.has_sign   = has_sign_reg;
        fmt.sign_char  = sign_char_reg;
        fmt.prefix_len = prefix_len_reg;
        fmt.lower      = lower_reg;
        fmt.pad        = (LEN_W'(fw_reg) > need) ? (LEN_W'(fw_reg) - need) : '0;
        fmt.extra      = prec - ndig_reg;
        fmt.ndig       = ndig_reg;
        // Output longer than the field limit is cut; a bad radix gives one character.
        if (bad_reg) begin
            fmt.out_len = LEN_W'(1);
        end else if (total > LEN_W'(MAX_FIELD)) begin
            fmt.out_len = LEN_W'(MAX_FIELD);
        end else begin
            fmt.out_len = total;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mag_reg        <= in_mag;
            radix_reg      <= s_radix;
            fw_reg         <= s_field_width;
            mind_reg       <= s_min_digits;
            bad_reg        <= in_bad;
            left_reg       <= s_left_justify;
            zpad_reg       <= s_zero_pad;
            lower_reg      <= s_lower_case;
            has_sign_reg   <= in_has_sign;
            sign_char_reg  <= in_sign_char;
            prefix_len_reg <= in_prefix_len;
            ndig_reg       <= '0;
        end else if (push) begin
            // The quotient becomes the next dividend; the remainder is a digit.
            mag_reg  <= div_quot;
            ndig_reg <= ndig_reg + 1'b1;
        end
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    irf_divider #(
        .VALUE_BITS(VALUE_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (mag_reg),
        .radix     (radix_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    irf_digit_stack #(
        .VALUE_BITS(VALUE_BITS)
    ) u_stack (
        .aclk (aclk),
        .push (push),
        .pop  (pop),
        .din  (div_rem),
        .top  (top_digit)
    );

    irf_emitter u_emitter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (emit_start),
        .fmt         (fmt),
        .digit       (top_digit),
        .pop         (pop),
        .done        (emit_done),
        .active      (emit_active),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_out  (m_char_out),
        .m_last      (m_last),
        .m_bad_radix (m_bad_radix)
    );

    // An error item is always a single, final, empty character.
    `IRF_ASSERT_SAME(a_bad_is_last, m_valid && m_bad_radix,
                     m_last && (m_char_out == CH_NUL), "bad radix item not final")
    // A new item is only taken once the emitter has let go of the previous one.
    `IRF_ASSERT_SAME(a_ready_idle, s_ready, !emit_active, "input ready while emitter busy")
    // Taking an item closes the input side on the next cycle.
    `IRF_ASSERT_NEXT(a_accept_closes, accept, !s_ready, "input still ready after accept")
    // The digit count cannot outgrow the digit stack.
    `IRF_ASSERT_SAME(a_ndig_bound, state_reg == S_SETUP,
                     ndig_reg <= LEN_W'(VALUE_BITS), "digit count overflow")

endmodule

`default_nettype wire

// ===== hw/rtl/irf_divider.sv =====
// ----------------------------------------------------------------------------
// irf_divider
// Shared restoring divider by the radix, DIV_R quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module irf_divider #(
    parameter int VALUE_BITS = irf_pkg::VALUE_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [VALUE_BITS-1:0]       dividend,
    input  wire logic [irf_pkg::DIGIT_W-1:0] radix,
    output logic                             done,
    output logic [VALUE_BITS-1:0]            quotient,
    output logic [irf_pkg::DIGIT_W-1:0]      remainder
);
    import irf_pkg::*;

    localparam int STEPS = (VALUE_BITS + DIV_R - 1) / DIV_R;
    localparam int DIV_W = STEPS * DIV_R;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIV_W-1:0]   q_reg, q_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [DIGIT_W:0]   trial;
    logic               ge;

    // DIV_R dependent compare-subtract steps on a 7-bit partial remainder.
    always_comb begin
        q_next   = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        trial    = '0;
        ge       = 1'b0;
        if (start) begin
            q_next   = DIV_W'(dividend);
            rem_next = '0;
            cnt_next = CNT_W'(STEPS);
        end else if (cnt_reg != '0) begin
            for (int k = 0; k < DIV_R; k++) begin
                trial = {rem_next, q_next[DIV_W-1]};
                ge    = (trial >= {1'b0, radix});
                if (ge) begin
                    trial = trial - {1'b0, radix};
                end
                q_next   = {q_next[DIV_W-2:0], ge};
                rem_next = trial[DIGIT_W-1:0];
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg[VALUE_BITS-1:0];
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/irf_digit_stack.sv =====
// ----------------------------------------------------------------------------
// irf_digit_stack
// Shift-register stack: digits arrive least significant first, leave reversed.
// ----------------------------------------------------------------------------
`default_nettype none

module irf_digit_stack #(
    parameter int VALUE_BITS = irf_pkg::VALUE_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        push,
    input  wire logic                        pop,
    input  wire logic [irf_pkg::DIGIT_W-1:0] din,
    output logic [irf_pkg::DIGIT_W-1:0]      top
);
    import irf_pkg::*;

    logic [DIGIT_W-1:0] stk_reg [VALUE_BITS];

    always_ff @(posedge aclk) begin
        if (push) begin
            stk_reg[0] <= din;
            for (int i = 1; i < VALUE_BITS; i++) begin
                stk_reg[i] <= stk_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
                stk_reg[i] <= stk_reg[i+1];
            end
        end
    end

    assign top = stk_reg[0];

endmodule

`default_nettype wire

// ===== hw/rtl/irf_emitter.sv =====
// ----------------------------------------------------------------------------
// irf_emitter
// Walks the output phases and drives the result item register.
// ----------------------------------------------------------------------------
`default_nettype none

module irf_emitter (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire irf_pkg::fmt_t               fmt,
    input  wire logic [irf_pkg::DIGIT_W-1:0] digit,
    output logic                             pop,
    output logic                             done,
    output logic                             active,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [7:0]                       m_char_out,
    output logic                             m_last,
    output logic                             m_bad_radix
);
    import irf_pkg::*;

    fmt_t             fmt_reg;
    logic             active_reg, active_next;
    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] sent_reg, sent_next;
    logic             valid_reg, valid_next;
    logic [7:0]       char_reg;
    logic             last_reg;
    logic             bad_reg;

    logic             slot_free;
    logic             emit;
    logic [7:0]       emit_char;
    logic             emit_last;
    phase_t           following;

    function automatic logic [LEN_W-1:0] phase_count(input phase_t ph, input fmt_t f);
        case (ph)
            PH_LEAD:  phase_count = f.lead_sp ? f.pad : '0;
            PH_SIGN:  phase_count = LEN_W'(f.has_sign);
            PH_PFX0:  phase_count = LEN_W'(f.prefix_len != 2'd0);
            PH_PFXX:  phase_count = LEN_W'(f.prefix_len == 2'd2);
            PH_ZPAD:  phase_count = f.zpad ? f.pad : '0;
            PH_PREC:  phase_count = f.extra;
            PH_DIGS:  phase_count = f.ndig;
            PH_TRAIL: phase_count = f.trail_sp ? f.pad : '0;
            PH_ERR:   phase_count = LEN_W'(1);
            default:  phase_count = '0;
        endcase
    endfunction

    assign slot_free = !valid_reg || m_ready;

    always_comb begin
        case (phase_reg)
            PH_LEAD:  following = PH_SIGN;
            PH_SIGN:  following = PH_PFX0;
            PH_PFX0:  following = PH_PFXX;
            PH_PFXX:  following = PH_ZPAD;
            PH_ZPAD:  following = PH_PREC;
            PH_PREC:  following = PH_DIGS;
            PH_DIGS:  following = PH_TRAIL;
            default:  following = PH_TRAIL;
        endcase
    end

    // Output logic: what goes into the result register this cycle.
    always_comb begin
        emit      = active_reg && slot_free && (cnt_reg != '0);
        emit_last = (sent_reg + 1'b1) == fmt_reg.out_len;
        case (phase_reg)
            PH_LEAD:  emit_char = CH_SPACE;
            PH_SIGN:  emit_char = fmt_reg.sign_char;
            PH_PFX0:  emit_char = CH_ZERO;
            PH_PFXX:  emit_char = digit_char(DIGIT_W'(X_DIGIT), fmt_reg.lower);
            PH_ZPAD:  emit_char = CH_ZERO;
            PH_PREC:  emit_char = CH_ZERO;
            PH_DIGS:  emit_char = digit_char(digit, fmt_reg.lower);
            PH_TRAIL: emit_char = CH_SPACE;
            default:  emit_char = CH_NUL;
        endcase
        pop  = emit && (phase_reg == PH_DIGS);
        done = emit && emit_last;
    end

    // Next-state logic of the phase walk.
    always_comb begin
        active_next = active_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        sent_next   = sent_reg;
        valid_next  = valid_reg && !m_ready;
        if (start) begin
            active_next = 1'b1;
            phase_next  = fmt.bad ? PH_ERR : PH_LEAD;
            cnt_next    = phase_count(fmt.bad ? PH_ERR : PH_LEAD, fmt);
            sent_next   = '0;
        end else if (active_reg && slot_free) begin
            if (cnt_reg == '0) begin
                phase_next = following;
                cnt_next   = phase_count(following, fmt_reg);
            end else begin
                valid_next = 1'b1;
                cnt_next   = cnt_reg - 1'b1;
                sent_next  = sent_reg + 1'b1;
                if (emit_last) begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            fmt_reg <= fmt;
        end
        if (emit) begin
            char_reg <= emit_char;
            last_reg <= emit_last;
            bad_reg  <= fmt_reg.bad;
        end
        phase_reg <= phase_next;
        cnt_reg   <= cnt_next;
        sent_reg  <= sent_next;
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    assign active      = active_reg;
    assign m_valid     = valid_reg;
    assign m_char_out  = char_reg;
    assign m_last      = last_reg;
    assign m_bad_radix = bad_reg;

endmodule

`default_nettype wire
